>>> design/vgpm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vgpm_pkg: shared types and constants for the voice gain and pan mixer
// Transaction payloads, register indexes, sample format codes and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package vgpm_pkg;

   // Default number of volume categories
   localparam int NUM_CATEGORIES_DEFAULT = 4;

   // Configuration port
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_GLOBAL_GAIN   = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_CAT_GAIN_BASE = 3'd1;

   // Gains, unsigned Q1.15
   localparam logic [15:0] GAIN_UNITY          = 16'd32768;
   localparam logic [15:0] GLOBAL_GAIN_RESET   = 16'd32768;
   localparam logic [15:0] CAT_GAIN_RESET      = 16'd27853;  // 0.85
   localparam logic [15:0] CAT_GAIN_MUSIC_RESET = 16'd16384; // 0.5, category 1

   // Sample format codes
   localparam logic [1:0] FMT_FLOAT32 = 2'd0;
   localparam logic [1:0] FMT_INT16   = 2'd1;
   localparam logic [1:0] FMT_UINT8   = 2'd2;

   typedef struct packed {
      logic [31:0]        sample_left;
      logic [31:0]        sample_right;
      logic [1:0]         sample_format;
      logic               stereo;
      logic [15:0]        voice_volume;
      logic signed [15:0] pan;
      logic [1:0]         category;
      logic               first_voice;
      logic               last_voice;
   } req_type;

   typedef struct packed {
      logic signed [15:0] mix_left;
      logic signed [15:0] mix_right;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_VOL_CAT,
      ST_GLOBAL,
      ST_PAN_L,
      ST_PAN_R,
      ST_MIX_L,
      ST_MIX_R,
      ST_ACC
   } state_type;

   // Multiplier step selected by the controller
   typedef enum logic [2:0] {
      OP_NONE,
      OP_VOL_CAT,
      OP_GLOBAL,
      OP_PAN_L,
      OP_PAN_R,
      OP_MIX_L,
      OP_MIX_R
   } op_type;

   typedef struct packed {
      logic   load;
      op_type op;
      logic   acc_en;
      logic   out_en;
   } cmd_type;

   typedef struct packed {
      logic last_voice;
   } status_type;

   // Reset value of a category gain register
   function automatic logic [15:0] cat_gain_reset(input int idx);
      logic [15:0] val;
      val = (idx == 1) ? CAT_GAIN_MUSIC_RESET : CAT_GAIN_RESET;
      return val;
   endfunction

endpackage
`default_nettype wire

>>> design/vgpm_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vgpm_ctrl: sequencing controller
// Steps one voice through the shared multiplier and owns the request
// stall and the result valid flag.
// ----------------------------------------------------------------------------
module vgpm_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire vgpm_pkg::status_type status,
   output vgpm_pkg::cmd_type         cmd
);
   import vgpm_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // State and result flag registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.op     = OP_NONE;
      cmd.acc_en = 1'b0;
      cmd.out_en = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_VOL_CAT;
            end
         end
         ST_VOL_CAT: begin
            cmd.op   = OP_VOL_CAT;
            state_in = ST_GLOBAL;
         end
         ST_GLOBAL: begin
            cmd.op   = OP_GLOBAL;
            state_in = ST_PAN_L;
         end
         ST_PAN_L: begin
            cmd.op   = OP_PAN_L;
            state_in = ST_PAN_R;
         end
         ST_PAN_R: begin
            cmd.op   = OP_PAN_R;
            state_in = ST_MIX_L;
         end
         ST_MIX_L: begin
            cmd.op   = OP_MIX_L;
            state_in = ST_MIX_R;
         end
         ST_MIX_R: begin
            cmd.op   = OP_MIX_R;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            // a frame end waits here while the output register is occupied
            if (!status.last_voice || out_free) begin
               cmd.acc_en = 1'b1;
               cmd.out_en = status.last_voice;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Result valid: set on emission, cleared once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

endmodule
`default_nettype wire

>>> design/vgpm_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vgpm_dp: mixer datapath
// Gain registers, sample conversion, one shared 17x17 signed multiplier,
// saturating accumulators and the output register.
// ----------------------------------------------------------------------------
module vgpm_dp #(
   parameter int NUM_CATEGORIES = vgpm_pkg::NUM_CATEGORIES_DEFAULT
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire vgpm_pkg::req_type                      req_payload,
   output vgpm_pkg::rsp_type                           rsp_payload,
   input  wire logic                                   csr_write,
   input  wire logic [vgpm_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [vgpm_pkg::CSR_DATA_WIDTH-1:0]    csr_data,
   input  wire vgpm_pkg::cmd_type                      cmd,
   output vgpm_pkg::status_type                        status
);
   import vgpm_pkg::*;

   // Gain clamp to unity
   function automatic logic [15:0] clamp_gain(input logic [15:0] g);
      logic [15:0] r;
      r = (g > GAIN_UNITY) ? GAIN_UNITY : g;
      return r;
   endfunction

   // Raw sample to Q1.15
   function automatic logic signed [15:0] convert(input logic [31:0] raw,
                                                  input logic [1:0]  fmt);
      logic        neg;
      logic [7:0]  ex;
      logic [22:0] man;
      logic [7:0]  sh;
      logic [23:0] mag24;
      logic [15:0] mag;
      logic [8:0]  two_x;
      logic [2:0]  k;
      logic [16:0] val;
      logic signed [15:0] r;
      neg   = raw[31];
      ex    = raw[30:23];
      man   = raw[22:0];
      sh    = 8'd135 - ex;
      mag24 = {1'b1, man} >> sh;
      mag   = mag24[15:0];
      two_x = {raw[7:0], 1'b0};
      // x * 32768 / 127 = 258x + floor(2x / 127)
      k     = 3'(two_x >= 9'd127) + 3'(two_x >= 9'd254)
            + 3'(two_x >= 9'd381) + 3'(two_x >= 9'd508);
      val   = {1'b0, raw[7:0], 8'd0} + {8'd0, raw[7:0], 1'b0} + {14'd0, k};
      r     = '0;
      unique case (fmt)
         FMT_FLOAT32: begin
            priority if (ex == 8'hFF && man != '0) r = '0;
            else if (ex >= 8'd127) r = neg ? 16'sh8000 : 16'sh7FFF;
            else if (ex == 8'd0)   r = '0;
            else                   r = neg ? -signed'(mag) : signed'(mag);
         end
         FMT_INT16: r = signed'(raw[15:0]);
         FMT_UINT8: r = val[16] ? 16'sh7FFF : signed'({~val[15], val[14:0]});
         default:   r = '0;
      endcase
      return r;
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [24:0] s);
      logic signed [23:0] r;
      if (s[24] != s[23]) r = s[24] ? 24'sh800000 : 24'sh7FFFFF;
      else                r = s[23:0];
      return r;
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [23:0] a);
      logic signed [15:0] r;
      if (a[23:15] == '0 || a[23:15] == '1) r = a[15:0];
      else                                  r = a[23] ? 16'sh8000 : 16'sh7FFF;
      return r;
   endfunction

   logic [15:0]        global_gain_ff;
   logic [15:0]        cat_gain_ff [NUM_CATEGORIES];
   req_type            item_ff;
   logic signed [15:0] sl_ff, sr_ff, conv_out;
   logic [31:0]        conv_raw;
   logic [15:0]        g_ff, lg_ff, rg_ff;
   logic signed [16:0] cl_ff;
   logic signed [31:0] prod_ff;
   logic signed [23:0] acc_left_ff, acc_right_ff;
   rsp_type            rsp_ff;

   logic [15:0]        vv_c, cg_c, gg_c, lf, rf, prod_u;
   logic [16:0]        lf_w, rf_w;
   logic signed [16:0] prod_s, mul_a, mul_b;
   logic signed [33:0] mul_full;
   logic signed [23:0] acc_l_base, acc_r_base, acc_l_new, acc_r_new;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         global_gain_ff <= GLOBAL_GAIN_RESET;
         for (int i = 0; i < NUM_CATEGORIES; i++) begin
            cat_gain_ff[i] <= cat_gain_reset(i);
         end
      end else if (csr_write) begin
         if (csr_index == CSR_GLOBAL_GAIN) begin
            global_gain_ff <= csr_data;
         end
         for (int i = 0; i < NUM_CATEGORIES; i++) begin
            if (csr_index == CSR_CAT_GAIN_BASE + CSR_INDEX_WIDTH'(i)) begin
               cat_gain_ff[i] <= csr_data;
            end
         end
      end
   end

   // Gain factors; a category outside the table is silent
   always_comb begin
      cg_c = '0;
      for (int i = 0; i < NUM_CATEGORIES; i++) begin
         if (item_ff.category == 2'(i)) cg_c = clamp_gain(cat_gain_ff[i]);
      end
   end
   assign vv_c = clamp_gain(item_ff.voice_volume);
   assign gg_c = clamp_gain(global_gain_ff);

   // Linear pan: only the opposite side is cut
   assign lf_w = 17'h08000 - {item_ff.pan[15], item_ff.pan};
   assign rf_w = 17'h08000 + {item_ff.pan[15], item_ff.pan};
   assign lf   = (item_ff.pan > 16'sd0) ? lf_w[15:0] : GAIN_UNITY;
   assign rf   = (item_ff.pan < 16'sd0) ? rf_w[15:0] : GAIN_UNITY;

   // One converter, left in the first step, right (or mono copy) in the second
   assign conv_raw = (cmd.op == OP_GLOBAL && item_ff.stereo) ?
                     item_ff.sample_right : item_ff.sample_left;
   assign conv_out = convert(conv_raw, item_ff.sample_format);

   // Product scaled back by 15, as unsigned gain and as floored signed value
   assign prod_u = prod_ff[30:15];
   assign prod_s = prod_ff[31:15];

   // Multiplier operand selection
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.op)
         OP_VOL_CAT: begin
            mul_a = signed'({1'b0, vv_c});
            mul_b = signed'({1'b0, cg_c});
         end
         OP_GLOBAL: begin
            mul_a = signed'({1'b0, prod_u});
            mul_b = signed'({1'b0, gg_c});
         end
         OP_PAN_L: begin
            mul_a = signed'({1'b0, prod_u});
            mul_b = signed'({1'b0, lf});
         end
         OP_PAN_R: begin
            mul_a = signed'({1'b0, g_ff});
            mul_b = signed'({1'b0, rf});
         end
         OP_MIX_L: begin
            mul_a = 17'(sl_ff);
            mul_b = signed'({1'b0, lg_ff});
         end
         OP_MIX_R: begin
            mul_a = 17'(sr_ff);
            mul_b = signed'({1'b0, rg_ff});
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end
   assign mul_full = mul_a * mul_b;

   // Item, product and intermediate gain registers
   always_ff @(posedge clock) begin
      if (cmd.load) item_ff <= req_payload;
      if (cmd.op != OP_NONE) prod_ff <= mul_full[31:0];
      if (cmd.op == OP_VOL_CAT) sl_ff <= conv_out;
      if (cmd.op == OP_GLOBAL)  sr_ff <= conv_out;
      if (cmd.op == OP_PAN_L)   g_ff  <= prod_u;
      if (cmd.op == OP_PAN_R)   lg_ff <= prod_u;
      if (cmd.op == OP_MIX_L)   rg_ff <= prod_u;
      if (cmd.op == OP_MIX_R)   cl_ff <= prod_s;
   end

   // Saturating accumulation, cleared by the first voice
   assign acc_l_base = item_ff.first_voice ? '0 : acc_left_ff;
   assign acc_r_base = item_ff.first_voice ? '0 : acc_right_ff;
   assign acc_l_new  = sat24(25'(acc_l_base) + 25'(cl_ff));
   assign acc_r_new  = sat24(25'(acc_r_base) + 25'(prod_s));

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_left_ff  <= '0;
         acc_right_ff <= '0;
      end else if (cmd.acc_en) begin
         acc_left_ff  <= acc_l_new;
         acc_right_ff <= acc_r_new;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (cmd.out_en) begin
         rsp_ff.mix_left  <= sat16(acc_l_new);
         rsp_ff.mix_right <= sat16(acc_r_new);
      end
   end

   assign rsp_payload       = rsp_ff;
   assign status.last_voice = item_ff.last_voice;

endmodule
`default_nettype wire

>>> design/voice_gain_pan_mixer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// voice_gain_pan_mixer: stereo voice mixer with gain and linear pan
// Converts one voice sample per transaction, applies voice, category and
// global gain and a linear pan, and sums into 24-bit accumulators.
//
//   channel   direction  handshake          carries
//   req_      in         valid / stall      one voice source frame
//   rsp_      out        valid / stall      mixed stereo frame (last voice)
//   csr_      in         valid / ready      register index and data
//
// From acceptance to the next acceptance a voice passes through six
// products in one shared 17x17 multiplier, one accumulate step and
// the idle state. The mixed frame appears the cycle after the last step.
// Reset clears the accumulators and loads the default gains.
// A last voice holds in its final step while an earlier frame is unread.
// ----------------------------------------------------------------------------
module voice_gain_pan_mixer #(
   parameter int NUM_CATEGORIES = vgpm_pkg::NUM_CATEGORIES_DEFAULT
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire vgpm_pkg::req_type                      req_payload,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output vgpm_pkg::rsp_type                           rsp_payload,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic [vgpm_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [vgpm_pkg::CSR_DATA_WIDTH-1:0]    csr_data
);
   import vgpm_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       csr_write;

   // Registers take a write in any cycle
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   vgpm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   vgpm_dp #(
      .NUM_CATEGORIES (NUM_CATEGORIES)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .status      (status)
   );

endmodule
`default_nettype wire

>>> dv/tb_voice_gain_pan_mixer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_voice_gain_pan_mixer: self-checking testbench for the voice mixer
// Drives voice transactions through a directed table and then random frames
// under several gain settings and idling patterns. Every accepted voice is
// run through a local model of the mixer. Every mixed frame is checked
// field by field against the oldest frame still due.
// ----------------------------------------------------------------------------
module tb_voice_gain_pan_mixer;
   import vgpm_pkg::*;

   localparam int     HALF_PERIOD   = 4;
   localparam int     RESET_CYCLES  = 2;
   localparam int     SETTLE_CYCLES = 16;
   localparam int     DRAIN_CYCLES  = 24;
   localparam int     QUIET_LIMIT   = 3000;  // cycles without any transaction
   localparam int     HOLD_CYCLES   = 240;   // long receiver hold-off
   localparam int     NUM_CATS      = NUM_CATEGORIES_DEFAULT;
   localparam int     LONG_RISE     = 300;   // drives the accumulators into the rail
   localparam int     LONG_FALL     = 256;   // brings a clipped sum back in range
   localparam longint UNITY         = 32768;
   localparam longint ACC_MAX       = 8388607;
   localparam longint ACC_MIN       = -8388608;
   localparam logic [1:0] FMT_UNUSED = 2'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_LO =
      CSR_CAT_GAIN_BASE + CSR_INDEX_WIDTH'(NUM_CATS);

   // Float32 patterns used by the directed table
   localparam logic [31:0] F_ONE       = 32'h3F80_0000;
   localparam logic [31:0] F_MINUS_ONE = 32'hBF80_0000;
   localparam logic [31:0] F_HALF      = 32'h3F00_0000;
   localparam logic [31:0] F_INF       = 32'h7F80_0000;
   localparam logic [31:0] F_NEG_INF   = 32'hFF80_0000;
   localparam logic [31:0] F_NAN       = 32'h7FC0_0000;
   localparam logic [31:0] F_DENORM    = 32'h0000_0001;

   typedef struct {
      req_type voice;
      bit      typed;   // frame below is the expected one, not the model's
      rsp_type frame;
   } voice_row_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   req_type                    req_payload = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   rsp_type                    rsp_payload;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data = '0;

   // Side information travelling with the offered voice
   bit                         offer_typed = 1'b0;
   rsp_type                    offer_frame = '0;

   // Model state: gain registers and accumulators
   logic [15:0]                glob_gain_cfg = GLOBAL_GAIN_RESET;
   logic [15:0]                cat_gain_cfg [NUM_CATS] = '{CAT_GAIN_RESET,
      CAT_GAIN_MUSIC_RESET, CAT_GAIN_RESET, CAT_GAIN_RESET};
   longint                     mix_acc_l = 0;
   longint                     mix_acc_r = 0;

   rsp_type                    frames_due [$];
   rsp_type                    predicted;
   rsp_type                    frame_now;
   int                         mismatch_count = 0;
   int                         req_idle_pct = 0;
   int                         rsp_idle_pct = 0;
   int                         hold_pending = 0;

   voice_gain_pan_mixer DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // Mixer model
   // ------------------------------------------------------------------------
   function automatic longint clip(input longint value, input longint lo, input longint hi);
      if (value > hi) return hi;
      if (value < lo) return lo;
      return value;
   endfunction

   function automatic longint clamp_unity(input logic [15:0] g);
      if (g > GAIN_UNITY) return UNITY;
      return longint'(g);
   endfunction

   // Raw sample bits to signed Q1.15
   function automatic int q15_from_raw(input logic [31:0] raw, input logic [1:0] fmt);
      int unsigned ex;
      int unsigned sh;
      logic [23:0] sig;
      int          mag;
      int          x;
      case (fmt)
         FMT_FLOAT32: begin
            ex = raw[30:23];
            if (ex == 255 && raw[22:0] != 0) return 0;       // NaN
            if (ex >= 127) return raw[31] ? -32768 : 32767;  // |v| >= 1 and infinities
            if (ex == 0) return 0;                           // zero and denormals
            sh  = 135 - ex;
            sig = {1'b1, raw[22:0]};
            mag = (sh >= 24) ? 0 : int'(sig >> sh);
            return raw[31] ? -mag : mag;
         end
         FMT_INT16: begin
            return int'($signed(raw[15:0]));
         end
         FMT_UINT8: begin
            x = raw[7:0];
            x = x * 32768 / 127 - 32768;
            return (x > 32767) ? 32767 : x;
         end
         default: begin
            return 0;
         end
      endcase
   endfunction

   // One voice into the accumulators; returns the frame it would emit
   function automatic rsp_type mix_voice(input req_type voice);
      longint  vol, cat, glob, gain, pan, lfac, rfac, lgain, rgain, sl, sr;
      rsp_type frame;
      vol   = clamp_unity(voice.voice_volume);
      cat   = (voice.category < NUM_CATS) ? clamp_unity(cat_gain_cfg[voice.category]) : 0;
      glob  = clamp_unity(glob_gain_cfg);
      sl    = q15_from_raw(voice.sample_left, voice.sample_format);
      sr    = voice.stereo ? q15_from_raw(voice.sample_right, voice.sample_format) : sl;
      gain  = (((vol * cat) >>> 15) * glob) >>> 15;
      pan   = $signed(voice.pan);
      // linear pan only cuts the opposite side
      lfac  = (pan > 0) ? UNITY - pan : UNITY;
      rfac  = (pan < 0) ? UNITY + pan : UNITY;
      lgain = (lfac * gain) >>> 15;
      rgain = (rfac * gain) >>> 15;
      if (voice.first_voice) begin
         mix_acc_l = 0;
         mix_acc_r = 0;
      end
      mix_acc_l = clip(mix_acc_l + ((sl * lgain) >>> 15), ACC_MIN, ACC_MAX);
      mix_acc_r = clip(mix_acc_r + ((sr * rgain) >>> 15), ACC_MIN, ACC_MAX);
      frame.mix_left  = 16'(clip(mix_acc_l, -32768, 32767));
      frame.mix_right = 16'(clip(mix_acc_r, -32768, 32767));
      return frame;
   endfunction

   // ------------------------------------------------------------------------
   // Monitors
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   // Register writes update the model's copy
   always @(posedge clock) begin
      if (!reset && csr_valid && csr_ready) begin
         if (csr_index == CSR_GLOBAL_GAIN)
            glob_gain_cfg = csr_data;
         else if (csr_index >= CSR_CAT_GAIN_BASE && csr_index < CSR_UNUSED_LO)
            cat_gain_cfg[csr_index - CSR_CAT_GAIN_BASE] = csr_data;
      end
   end

   // Accepted voice: advance the model, queue a frame on the last voice
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         predicted = mix_voice(req_payload);
         if (req_payload.last_voice)
            frames_due.push_back(offer_typed ? offer_frame : predicted);
      end
   end

   // Accepted frame against the oldest one due
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (frames_due.size() == 0) begin
            report_mismatch($sformatf("frame %0d/%0d with nothing due",
               rsp_payload.mix_left, rsp_payload.mix_right));
         end else begin
            frame_now = frames_due.pop_front();
            if (rsp_payload.mix_left !== frame_now.mix_left)
               report_mismatch($sformatf("mix_left got %0d expected %0d",
                  rsp_payload.mix_left, frame_now.mix_left));
            if (rsp_payload.mix_right !== frame_now.mix_right)
               report_mismatch($sformatf("mix_right got %0d expected %0d",
                  rsp_payload.mix_right, frame_now.mix_right));
         end
      end
   end

   // Receiver back-pressure, with an optional long hold-off
   initial begin : rsp_backpressure
      int held;
      held = 0;
      forever begin
         @(negedge clock);
         if (hold_pending != 0) begin
            held = hold_pending;
            hold_pending = 0;
         end
         if (held > 0) begin
            rsp_stall <= 1'b1;
            held--;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   // Watchdog: too long without any transaction ends the run
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Regression FAIL");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic voice_row_type make_row(input logic [31:0] sl, input logic [31:0] sr,
                                              input logic [1:0] fmt, input bit stereo,
                                              input logic [15:0] vol, input logic [15:0] pan,
                                              input logic [1:0] cat, input bit first,
                                              input bit last, input bit typed,
                                              input int exp_l, input int exp_r);
      voice_row_type row;
      row.voice.sample_left   = sl;
      row.voice.sample_right  = sr;
      row.voice.sample_format = fmt;
      row.voice.stereo        = stereo;
      row.voice.voice_volume  = vol;
      row.voice.pan           = pan;
      row.voice.category      = cat;
      row.voice.first_voice   = first;
      row.voice.last_voice    = last;
      row.typed               = typed;
      row.frame.mix_left      = 16'(exp_l);
      row.frame.mix_right     = 16'(exp_r);
      return row;
   endfunction

   function automatic logic [31:0] random_sample(input logic [1:0] fmt);
      int          pick;
      logic [31:0] bits;
      pick = $urandom_range(99);
      bits = $urandom;
      if (fmt == FMT_FLOAT32) begin
         if (pick < 55)
            bits[30:23] = 8'($urandom_range(110, 126));   // inside (-1, 1)
         else if (pick < 70)
            bits[30:23] = 8'($urandom_range(127, 160));   // saturating
         else if (pick < 80)
            bits[30:23] = 8'hFF;                          // NaN and infinities
         else if (pick < 88)
            bits[30:23] = 8'h00;                          // zero and denormals
      end else if (pick < 15) begin
         bits[15:0] = pick[0] ? 16'h7FFF : 16'h8000;
      end
      return bits;
   endfunction

   function automatic req_type random_voice();
      req_type voice;
      int      pick;
      voice.sample_format = ($urandom_range(99) < 8) ? FMT_UNUSED : 2'($urandom_range(2));
      voice.sample_left   = random_sample(voice.sample_format);
      voice.sample_right  = random_sample(voice.sample_format);
      voice.stereo        = $urandom_range(1);
      pick = $urandom_range(99);
      if (pick < 8)       voice.voice_volume = '0;
      else if (pick < 20) voice.voice_volume = GAIN_UNITY;
      else if (pick < 30) voice.voice_volume = 16'($urandom);
      else                voice.voice_volume = 16'($urandom_range(32768));
      pick = $urandom_range(99);
      if (pick < 10)      voice.pan = 16'h8000;
      else if (pick < 20) voice.pan = 16'h7FFF;
      else if (pick < 30) voice.pan = '0;
      else                voice.pan = 16'($urandom);
      voice.category    = 2'($urandom_range(3));
      voice.first_voice = 1'b0;
      voice.last_voice  = 1'b0;
      return voice;
   endfunction

   // Offer one voice and hold it until accepted; starts and ends at a falling edge
   task automatic send_voice(input req_type voice, input bit typed, input rsp_type frame);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= voice;
      offer_typed <= typed;
      offer_frame <= frame;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] index, input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   // Idling is changed away from the falling edge where the stall process acts
   task automatic set_idling(input int sender_pct, input int receiver_pct, input int hold);
      @(posedge clock);
      req_idle_pct = sender_pct;
      rsp_idle_pct = receiver_pct;
      hold_pending = hold;
      @(negedge clock);
   endtask

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin : stimulus
      voice_row_type rows [$];
      req_type       voice;
      logic [15:0]   gains [5];
      int            phase, k, u, budget, sent, len, up;
      bit            broken;

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // Directed table, run at the reset gains (category 1 is one half)
      //                    left         right        format       st vol    pan
      //                    cat fst lst typed  left    right
      rows.push_back(make_row(32'h7FFF,    '0,          FMT_INT16,   0, 16'd32768, 16'h0000,
                              1, 1, 1, 1,  16383,  16383));
      rows.push_back(make_row(32'hFFFF8000, '0,         FMT_INT16,   0, 16'd32768, 16'h0000,
                              1, 1, 1, 1, -16384, -16384));
      rows.push_back(make_row(F_ONE,       F_MINUS_ONE, FMT_FLOAT32, 1, 16'd32768, 16'h0000,
                              1, 1, 1, 1,  16383, -16384));
      rows.push_back(make_row(F_INF,       F_NEG_INF,   FMT_FLOAT32, 1, 16'd32768, 16'h0000,
                              1, 1, 1, 1,  16383, -16384));
      rows.push_back(make_row(F_NAN,       F_DENORM,    FMT_FLOAT32, 1, 16'd32768, 16'h0000,
                              1, 1, 1, 1,      0,      0));
      rows.push_back(make_row(F_HALF,      '0,          FMT_FLOAT32, 0, 16'd32768, 16'h0000,
                              1, 1, 1, 1,   8192,   8192));
      rows.push_back(make_row(32'h3E9A1234, 32'hC0490FDB, FMT_FLOAT32, 1, 16'd30000, 16'h1000,
                              0, 1, 1, 0, 0, 0));
      rows.push_back(make_row(32'h00,      32'h7F,      FMT_UINT8,   1, 16'd32768, 16'h0000,
                              1, 1, 1, 1, -16384,      0));
      rows.push_back(make_row(32'hFFFFFFFF, '0,         FMT_UINT8,   0, 16'd32768, 16'h0000,
                              1, 1, 1, 1,  16383,  16383));
      // unused format code is silence
      rows.push_back(make_row(32'h7FFF,    F_ONE,       FMT_UNUSED,  1, 16'd32768, 16'h0000,
                              1, 1, 1, 1,      0,      0));
      rows.push_back(make_row(32'h7FFF,    '0,          FMT_INT16,   0, 16'd0,     16'h0000,
                              1, 1, 1, 1,      0,      0));
      // pan extremes
      rows.push_back(make_row(32'h7FFF,    32'h7FFF,    FMT_INT16,   1, 16'd32768, 16'h8000,
                              1, 1, 1, 1,  16383,      0));
      rows.push_back(make_row(32'h7FFF,    32'h7FFF,    FMT_INT16,   1, 16'd32768, 16'h7FFF,
                              1, 1, 1, 1,      0,  16383));
      // volume above unity is clamped
      rows.push_back(make_row(32'h7FFF,    '0,          FMT_INT16,   0, 16'hFFFF,  16'h0000,
                              1, 1, 1, 1,  16383,  16383));
      rows.push_back(make_row(32'h4000,    '0,          FMT_INT16,   0, 16'd32768, 16'h0000,
                              0, 1, 1, 0, 0, 0));
      rows.push_back(make_row(32'h1234,    32'hEDCB,    FMT_INT16,   1, 16'd20000, 16'h2000,
                              2, 1, 1, 0, 0, 0));
      rows.push_back(make_row(32'h3F7FFFFF, '0,         FMT_FLOAT32, 0, 16'd32768, 16'hE000,
                              3, 1, 1, 0, 0, 0));
      // three loud voices clip the 16-bit output
      rows.push_back(make_row(32'h7FFF,    '0,          FMT_INT16,   0, 16'd32768, 16'h0000,
                              1, 1, 0, 0, 0, 0));
      rows.push_back(make_row(32'h7FFF,    '0,          FMT_INT16,   0, 16'd32768, 16'h0000,
                              1, 0, 0, 0, 0, 0));
      rows.push_back(make_row(32'h7FFF,    '0,          FMT_INT16,   0, 16'd32768, 16'h0000,
                              1, 0, 1, 1,  32767,  32767));
      // frame without a first voice carries on from the old sums
      rows.push_back(make_row(32'h8000,    '0,          FMT_INT16,   0, 16'd32768, 16'h0000,
                              1, 0, 1, 0, 0, 0));
      rows.push_back(make_row(32'h8000,    '0,          FMT_INT16,   0, 16'd32768, 16'h0000,
                              1, 1, 0, 0, 0, 0));
      rows.push_back(make_row(32'h8000,    '0,          FMT_INT16,   0, 16'd32768, 16'h0000,
                              1, 0, 0, 0, 0, 0));
      rows.push_back(make_row(32'h8000,    '0,          FMT_INT16,   0, 16'd32768, 16'h0000,
                              1, 0, 1, 1, -32768, -32768));

      set_idling(6, 66, 0);
      foreach (rows[i]) send_voice(rows[i].voice, rows[i].typed, rows[i].frame);
      req_valid <= 1'b0;

      for (phase = 0; phase < 6; phase++) begin
         // idle before touching the registers
         while (frames_due.size() != 0) @(negedge clock);
         repeat (SETTLE_CYCLES) @(negedge clock);

         case (phase)
            0: begin
               gains = '{GAIN_UNITY, GAIN_UNITY, GAIN_UNITY, GAIN_UNITY, GAIN_UNITY};
               budget = 200;
            end
            1: begin
               gains = '{16'hFFFF, 16'd32769, 16'hFFFF, 16'd40000, 16'd50000};
               budget = 220;
            end
            2: begin
               foreach (gains[g]) gains[g] = 16'($urandom_range(32768));
               budget = 220;
            end
            3: begin
               gains = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
               budget = 60;
            end
            4: begin
               foreach (gains[g]) gains[g] = 16'($urandom);
               budget = 220;
            end
            default: begin
               gains = '{16'($urandom_range(1, 32768)), CAT_GAIN_RESET,
                         CAT_GAIN_MUSIC_RESET, CAT_GAIN_RESET, CAT_GAIN_RESET};
               budget = 220;
            end
         endcase
         for (k = 0; k < 5; k++)
            write_reg((k == 0) ? CSR_GLOBAL_GAIN : CSR_CAT_GAIN_BASE + 3'(k - 1), gains[k]);
         // indexes past the last category must be ignored
         if (phase == 1 || phase == 4)
            for (u = CSR_UNUSED_LO; u < (1 << CSR_INDEX_WIDTH); u++)
               write_reg(3'(u), 16'($urandom));
         csr_valid <= 1'b0;

         if (phase < 2)
            set_idling(6, 66, 0);
         else if (phase < 4)
            set_idling(66, 6, 0);
         else
            set_idling(0, 0, (phase == 4) ? HOLD_CYCLES : 0);

         // one long frame at unity gain: clip the 24-bit sums, then come back
         if (phase == 0) begin
            up = $urandom_range(1);
            for (k = 0; k <= LONG_RISE + LONG_FALL; k++) begin
               voice = random_voice();
               if (k < LONG_RISE + LONG_FALL) begin
                  voice.sample_format = FMT_INT16;
                  voice.stereo        = 1'b0;
                  voice.voice_volume  = GAIN_UNITY;
                  voice.pan           = '0;
                  voice.sample_left   = {16'($urandom),
                     (((k < LONG_RISE) ? 1 : 0) ^ up) ? 16'h8000 : 16'h7FFF};
               end
               voice.first_voice = (k == 0);
               voice.last_voice  = (k == LONG_RISE + LONG_FALL);
               send_voice(voice, 1'b0, '0);
            end
         end

         // random frames, mostly well formed, some with random flags
         sent = 0;
         while (sent < budget) begin
            len    = ($urandom_range(99) < 70) ? $urandom_range(1, 4) : $urandom_range(5, 12);
            broken = ($urandom_range(99) < 12);
            for (k = 0; k < len; k++) begin
               voice = random_voice();
               voice.first_voice = broken ? 1'($urandom_range(1)) : (k == 0);
               voice.last_voice  = broken ? 1'($urandom_range(1)) : (k == len - 1);
               send_voice(voice, 1'b0, '0);
               sent++;
            end
         end
         req_valid <= 1'b0;
      end

      // drain
      while (frames_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

>>> filelist.f
design/vgpm_pkg.sv
design/vgpm_ctrl.sv
design/vgpm_dp.sv
design/voice_gain_pan_mixer.sv
dv/tb_voice_gain_pan_mixer.sv
